### design/bdpc_pkg.sv
// Package: types, constants and register codes of the button debounce press classifier.
`default_nettype none

package bdpc_pkg;

    // Number of buttons handled in parallel
    localparam int NUM_BUTTONS = 2;

    // Counter widths and limits
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration registers
    localparam int CFG_ADDR_W = 8;
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_TICKS   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS_TICKS = 8'd1;
    localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RST   = 16'd50;
    localparam logic [CNT_W-1:0] LONG_PRESS_TICKS_RST = 16'd3000;

    // Per-button event codes
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    // One tick word: raw levels, 1 means pressed
    typedef struct packed {
        logic next_level;
        logic prev_level;
    } t_tick;

    // One result word
    typedef struct packed {
        logic [1:0] next_event;
        logic [1:0] prev_event;
        logic       next_down;
        logic       prev_down;
    } t_result;

endpackage

`default_nettype wire

### design/bdpc_if.sv
// Interfaces: tick, result and configuration channels.
`default_nettype none

// Tick channel
interface bdpc_tick_if;
    logic                valid;
    logic                ready;
    bdpc_pkg::t_tick     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel
interface bdpc_res_if;
    logic                valid;
    logic                ready;
    bdpc_pkg::t_result   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel
interface bdpc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bdpc_pkg::CFG_ADDR_W-1:0]     addr;
    logic [bdpc_pkg::CNT_W-1:0]          wdata;

    modport source (output valid, output addr, output wdata, input ready);
    modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

### design/button_debounce_press_classifier.sv
// Top level: two-button debouncer with short and long press classification.
//
// Usage:
//   i_tick carries one word per millisecond tick with the raw level of each
//   button. o_res returns one word per tick: an event per button (none,
//   short press, long press) and the debounced pressed flag after that tick.
//   i_cfg writes debounce_ticks (addr 0) and long_press_ticks (addr 1); other
//   addresses are ignored. It is always ready; write only while idle.
// Timing:
//   Two stages: an input register and a result register. A result is valid
//   on o_res once its tick word has passed the input register and been
//   written to the result register. One tick per cycle is sustained while
//   o_res is not held; the combinational per-button update allows that rate.
// Reset (i_rst_n low, synchronous):
//   Pipeline empty, all button state zero, registers back to 50 and 3000.
// Stall:
//   While o_res is held (valid without ready) the pipeline stops; i_tick
//   still takes one word into the input register if it is empty, then
//   deasserts ready until the result is taken.
`default_nettype none

module button_debounce_press_classifier (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bdpc_tick_if.sink   i_tick,
    bdpc_res_if.source  o_res,
    bdpc_cfg_if.sink    i_cfg
);
    import bdpc_pkg::*;

    // Configuration registers
    logic [CNT_W-1:0] r_debounce_ticks;
    logic [CNT_W-1:0] r_long_press_ticks;

    // Pipeline registers
    logic                   r_s1_valid;
    logic [NUM_BUTTONS-1:0] r_s1_level;
    logic                   r_out_valid;
    t_result                r_out;

    // Per-button state
    logic [NUM_BUTTONS-1:0] r_last_raw,  n_last_raw;
    logic [NUM_BUTTONS-1:0] r_pending,   n_pending;
    logic [CNT_W-1:0]       r_sample_cnt [NUM_BUTTONS];
    logic [CNT_W-1:0]       n_sample_cnt [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_down,      n_down;
    logic [CNT_W-1:0]       r_hold_cnt   [NUM_BUTTONS];
    logic [CNT_W-1:0]       n_hold_cnt   [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_armed,     n_armed;
    t_event                 n_event      [NUM_BUTTONS];

    logic out_free;
    logic s1_advance;
    logic tick_accept;

    // Handshake
    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_advance  = r_s1_valid && out_free;
    assign i_tick.ready = !r_s1_valid || out_free;
    assign tick_accept = i_tick.valid && i_tick.ready;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks   <= DEBOUNCE_TICKS_RST;
            r_long_press_ticks <= LONG_PRESS_TICKS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                REG_DEBOUNCE_TICKS:   r_debounce_ticks   <= i_cfg.wdata;
                REG_LONG_PRESS_TICKS: r_long_press_ticks <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_s1_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_accept) begin
            r_s1_level <= {i_tick.data.prev_level, i_tick.data.next_level};
        end
    end

    // Per-button debounce, sampling and press classification
    always_comb begin
        logic raw;
        logic sampled;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            raw     = r_s1_level[b];
            sampled = 1'b0;
            n_pending[b]    = r_pending[b];
            n_sample_cnt[b] = r_sample_cnt[b];
            n_down[b]       = r_down[b];
            n_hold_cnt[b]   = r_hold_cnt[b];
            n_armed[b]      = r_armed[b];
            n_event[b]      = EV_NONE;

            // first raw edge arms the sampling delay
            if (raw != r_last_raw[b] && !r_pending[b]) begin
                n_pending[b]    = 1'b1;
                n_sample_cnt[b] = '0;
            end
            n_last_raw[b] = raw;

            // delay running: count, sample when it expires
            if (r_pending[b]) begin
                if (r_sample_cnt[b] != CNT_MAX) begin
                    n_sample_cnt[b] = r_sample_cnt[b] + 1'b1;
                end
                if (n_sample_cnt[b] >= r_debounce_ticks) begin
                    n_pending[b] = 1'b0;
                    sampled      = 1'b1;
                end
            end

            // evaluate the sample
            if (sampled) begin
                if (raw && !r_down[b]) begin
                    n_hold_cnt[b] = '0;
                    n_armed[b]    = 1'b1;
                end else if (!raw && r_down[b]) begin
                    n_armed[b] = 1'b0;
                    if (r_hold_cnt[b] < r_long_press_ticks) begin
                        n_event[b] = EV_SHORT;
                    end
                end
                n_down[b] = raw;
            end

            // long press, reported once per press
            if (n_down[b] && n_armed[b] && n_hold_cnt[b] >= r_long_press_ticks) begin
                n_event[b] = EV_LONG;
                n_armed[b] = 1'b0;
            end

            // saturating hold counter
            if (n_down[b] && n_hold_cnt[b] != CNT_MAX) begin
                n_hold_cnt[b] = n_hold_cnt[b] + 1'b1;
            end
        end
    end

    // State update, one tick per advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw <= '0;
            r_pending  <= '0;
            r_down     <= '0;
            r_armed    <= '0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_sample_cnt[b] <= '0;
                r_hold_cnt[b]   <= '0;
            end
        end else if (s1_advance) begin
            r_last_raw <= n_last_raw;
            r_pending  <= n_pending;
            r_down     <= n_down;
            r_armed    <= n_armed;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_sample_cnt[b] <= n_sample_cnt[b];
                r_hold_cnt[b]   <= n_hold_cnt[b];
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out.next_event <= n_event[0];
            r_out.prev_event <= n_event[1];
            r_out.next_down  <= n_down[0];
            r_out.prev_down  <= n_down[1];
        end
    end

endmodule

`default_nettype wire

### design/bdpc_checker.sv
// Checker: port-level assertions for the press classifier, bound to the top level.
`default_nettype none

module bdpc_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_res_valid,
    input wire                      i_res_ready,
    input wire bdpc_pkg::t_result   i_res_data
);
    import bdpc_pkg::*;

    // a stalled result word holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_data)))
        else $error("result word changed while stalled");

    // reset leaves the pipeline empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // a long press is reported only while the button is down
    a_long_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |->
            ((i_res_data.next_event != EV_LONG || i_res_data.next_down) &&
             (i_res_data.prev_event != EV_LONG || i_res_data.prev_down)))
        else $error("long press reported with button up");

    // a short press is reported only on release
    a_short_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |->
            ((i_res_data.next_event != EV_SHORT || !i_res_data.next_down) &&
             (i_res_data.prev_event != EV_SHORT || !i_res_data.prev_down)))
        else $error("short press reported with button down");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);

`default_nettype wire
